[src/nearest_symbol_search_assert.svh]
// ----------------------------------------------------------------------------
// nearest_symbol_search_assert.svh
// assertion macros shared by the nearest symbol search modules
// ----------------------------------------------------------------------------
`ifndef NEAREST_SYMBOL_SEARCH_ASSERT_SVH
`define NEAREST_SYMBOL_SEARCH_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NSS_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("nearest symbol search: assertion failed");

// next-cycle implication, disabled during reset
`define NSS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("nearest symbol search: assertion failed");

`endif

[src/nss_pkg.sv]
// ----------------------------------------------------------------------------
// nss_pkg
// shared types and constants of the nearest symbol search block
// ----------------------------------------------------------------------------
package nss_pkg;

  // result status codes
  localparam logic [1:0] STATUS_EXACT  = 2'd0;
  localparam logic [1:0] STATUS_LOWER  = 2'd1;
  localparam logic [1:0] STATUS_HIGHER = 2'd2;
  localparam logic [1:0] STATUS_NONE   = 2'd3;

  // query modes (any other code means exact only)
  localparam logic [1:0] MODE_LOWER  = 2'd1;
  localparam logic [1:0] MODE_HIGHER = 2'd2;

  // parameter defaults
  localparam int MAX_ENTRIES_DEF = 4096;
  localparam int ADDR_WIDTH_DEF  = 32;

  // depth of the queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;

  // field widths of the result beat
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 12;
  localparam int OFFSET_W = 32;
  localparam int VALUE_W  = 32;

  // classification of one entry, handed from front to back
  typedef struct packed {
    logic       below;
    logic       above;
    logic       last;
    logic [1:0] mode;
  } nss_cls_t;

endpackage

[src/nss_front.sv]
// ----------------------------------------------------------------------------
// nss_front
// run tracking and per-entry classification against the query address
// ----------------------------------------------------------------------------
module nss_front #(
  parameter int ADDR_WIDTH  = nss_pkg::ADDR_WIDTH_DEF,
  parameter int MAX_ENTRIES = nss_pkg::MAX_ENTRIES_DEF,
  localparam int CW = $clog2(MAX_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [nss_pkg::VALUE_W-1:0]   sym_value,
  input  logic [nss_pkg::VALUE_W-1:0]   query_addr,
  input  logic [1:0]                    mode,
  input  logic                          last_entry,
  output nss_pkg::nss_cls_t             rec_cls,
  output logic [CW-1:0]                 rec_index,
  output logic [ADDR_WIDTH-1:0]         rec_dist
);

  logic                  run_active_r, run_active_nxt;
  logic [ADDR_WIDTH-1:0] held_addr_r, held_addr_nxt;
  logic [1:0]            held_mode_r, held_mode_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  logic [ADDR_WIDTH-1:0] value;
  logic [ADDR_WIDTH-1:0] addr;
  logic [1:0]            cur_mode;
  logic [CW-1:0]         idx;
  logic                  is_below;
  logic                  is_above;

  always_comb begin
    value    = ADDR_WIDTH'(sym_value);
    addr     = run_active_r ? held_addr_r : ADDR_WIDTH'(query_addr);
    cur_mode = run_active_r ? held_mode_r : mode;
    idx      = run_active_r ? cnt_r : '0;
    is_below = value < addr;
    is_above = value > addr;

    rec_cls.below = is_below;
    rec_cls.above = is_above;
    rec_cls.last  = last_entry;
    rec_cls.mode  = cur_mode;
    rec_index     = idx;
    rec_dist      = is_below ? (addr - value) : (value - addr);
  end

  always_comb begin
    run_active_nxt = run_active_r;
    held_addr_nxt  = held_addr_r;
    held_mode_nxt  = held_mode_r;
    cnt_nxt        = cnt_r;
    if (accept) begin
      run_active_nxt = !last_entry;
      held_addr_nxt  = addr;
      held_mode_nxt  = cur_mode;
      // index wraps after the last slot
      cnt_nxt        = (idx == CW'(MAX_ENTRIES - 1)) ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      run_active_r <= run_active_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_addr_r <= held_addr_nxt;
    held_mode_r <= held_mode_nxt;
  end

endmodule

[src/nss_queue.sv]
// ----------------------------------------------------------------------------
// nss_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`include "nearest_symbol_search_assert.svh"

module nss_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nss_pkg::QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    full       = cnt_r == NW'(DEPTH);
    empty      = cnt_r == '0;
    rdata      = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `NSS_ASSERT_IMPLY(a_q_no_overflow, clk, rst_n, push, !full || pop)
  `NSS_ASSERT_IMPLY(a_q_no_underflow, clk, rst_n, pop, !empty)
  `NSS_ASSERT_IMPLY(a_q_count_bound, clk, rst_n, 1'b1, cnt_r <= NW'(DEPTH))

endmodule

[src/nss_back.sv]
// ----------------------------------------------------------------------------
// nss_back
// nearest below / above / exact tracking and result register
// ----------------------------------------------------------------------------
`include "nearest_symbol_search_assert.svh"

module nss_back #(
  parameter int ADDR_WIDTH  = nss_pkg::ADDR_WIDTH_DEF,
  parameter int MAX_ENTRIES = nss_pkg::MAX_ENTRIES_DEF,
  localparam int CW = $clog2(MAX_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rec_valid,
  input  nss_pkg::nss_cls_t             rec_cls,
  input  logic [CW-1:0]                 rec_index,
  input  logic [ADDR_WIDTH-1:0]         rec_dist,
  output logic                          rec_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [nss_pkg::STATUS_W-1:0]  out_status,
  output logic [nss_pkg::INDEX_W-1:0]   out_entry_index,
  output logic [nss_pkg::OFFSET_W-1:0]  out_offset
);

  // trackers
  logic                  below_valid_r, below_valid_nxt;
  logic [ADDR_WIDTH-1:0] below_dist_r, below_dist_nxt;
  logic [CW-1:0]         below_index_r, below_index_nxt;
  logic                  above_valid_r, above_valid_nxt;
  logic [ADDR_WIDTH-1:0] above_dist_r, above_dist_nxt;
  logic [CW-1:0]         above_index_r, above_index_nxt;
  logic                  exact_valid_r, exact_valid_nxt;
  logic [CW-1:0]         exact_index_r, exact_index_nxt;

  // result register
  logic                          res_valid_r, res_valid_nxt;
  logic [nss_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [nss_pkg::INDEX_W-1:0]   res_index_r, res_index_nxt;
  logic [nss_pkg::OFFSET_W-1:0]  res_offset_r, res_offset_nxt;

  logic take;
  logic take_last;
  logic upd_below;
  logic upd_above;
  logic upd_exact;

  always_comb begin
    // a last entry needs a free result slot, other entries never wait
    rec_pop   = rec_valid && (!rec_cls.last || !res_valid_r || out_pop);
    take      = rec_pop;
    take_last = take && rec_cls.last;

    upd_below = take && rec_cls.below && (!below_valid_r || rec_dist < below_dist_r);
    upd_above = take && rec_cls.above && (!above_valid_r || rec_dist < above_dist_r);
    upd_exact = take && !rec_cls.below && !rec_cls.above;

    below_valid_nxt = below_valid_r || upd_below;
    below_dist_nxt  = upd_below ? rec_dist : below_dist_r;
    below_index_nxt = upd_below ? rec_index : below_index_r;
    above_valid_nxt = above_valid_r || upd_above;
    above_dist_nxt  = upd_above ? rec_dist : above_dist_r;
    above_index_nxt = upd_above ? rec_index : above_index_r;
    exact_valid_nxt = exact_valid_r || upd_exact;
    exact_index_nxt = upd_exact ? rec_index : exact_index_r;

    // result priority: exact, then the neighbor the mode asks for
    res_status_nxt = nss_pkg::STATUS_NONE;
    res_index_nxt  = '0;
    res_offset_nxt = '0;
    if (exact_valid_nxt) begin
      res_status_nxt = nss_pkg::STATUS_EXACT;
      res_index_nxt  = nss_pkg::INDEX_W'(exact_index_nxt);
    end else if (rec_cls.mode == nss_pkg::MODE_LOWER && below_valid_nxt) begin
      res_status_nxt = nss_pkg::STATUS_LOWER;
      res_index_nxt  = nss_pkg::INDEX_W'(below_index_nxt);
      res_offset_nxt = nss_pkg::OFFSET_W'(below_dist_nxt);
    end else if (rec_cls.mode == nss_pkg::MODE_HIGHER && above_valid_nxt) begin
      res_status_nxt = nss_pkg::STATUS_HIGHER;
      res_index_nxt  = nss_pkg::INDEX_W'(above_index_nxt);
      res_offset_nxt = nss_pkg::OFFSET_W'(above_dist_nxt);
    end

    res_valid_nxt = take_last ? 1'b1 : (res_valid_r && !out_pop);

    out_empty       = !res_valid_r;
    out_status      = res_status_r;
    out_entry_index = res_index_r;
    out_offset      = res_offset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      below_valid_r <= 1'b0;
      above_valid_r <= 1'b0;
      exact_valid_r <= 1'b0;
      res_valid_r   <= 1'b0;
    end else begin
      // the run ends with its last entry, so the trackers start over
      below_valid_r <= take_last ? 1'b0 : below_valid_nxt;
      above_valid_r <= take_last ? 1'b0 : above_valid_nxt;
      exact_valid_r <= take_last ? 1'b0 : exact_valid_nxt;
      res_valid_r   <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    below_dist_r  <= below_dist_nxt;
    below_index_r <= below_index_nxt;
    above_dist_r  <= above_dist_nxt;
    above_index_r <= above_index_nxt;
    exact_index_r <= exact_index_nxt;
    if (take_last) begin
      res_status_r <= res_status_nxt;
      res_index_r  <= res_index_nxt;
      res_offset_r <= res_offset_nxt;
    end
  end

  `NSS_ASSERT_NEXT(a_bk_clear_after_last, clk, rst_n, take_last, !below_valid_r && !above_valid_r && !exact_valid_r)
  `NSS_ASSERT_IMPLY(a_bk_exact_zero_offset, clk, rst_n, res_valid_r && res_status_r == nss_pkg::STATUS_EXACT, res_offset_r == '0)
  `NSS_ASSERT_IMPLY(a_bk_none_zero_fields, clk, rst_n, res_valid_r && res_status_r == nss_pkg::STATUS_NONE, res_offset_r == '0 && res_index_r == '0)

endmodule

[src/nearest_symbol_search.sv]
// result: a beat is offered once a run's last entry has left the queue and been registered
// throughput: one entry beat per cycle, set by the one-pass compare in the front and the
//   single tracker update in the back; a waiting result stalls a following last entry
// reset: synchronous, active low; clears the run state, the queue and the result register
// ----------------------------------------------------------------------------
// nearest_symbol_search
// nearest predecessor / successor search over a streamed symbol table
// ----------------------------------------------------------------------------
module nearest_symbol_search #(
  parameter int MAX_ENTRIES = nss_pkg::MAX_ENTRIES_DEF,
  parameter int ADDR_WIDTH  = nss_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // entry channel
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [nss_pkg::VALUE_W-1:0]   in_sym_value,
  input  logic [nss_pkg::VALUE_W-1:0]   in_query_addr,
  input  logic [1:0]                    in_mode,
  input  logic                          in_last_entry,
  // result channel
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [nss_pkg::STATUS_W-1:0]  out_status,
  output logic [nss_pkg::INDEX_W-1:0]   out_entry_index,
  output logic [nss_pkg::OFFSET_W-1:0]  out_offset
);

  // entry index width and width of one queued record
  localparam int CW    = $clog2(MAX_ENTRIES);
  localparam int CLS_W = $bits(nss_pkg::nss_cls_t);
  localparam int REC_W = CLS_W + CW + ADDR_WIDTH;

  logic                  accept;
  nss_pkg::nss_cls_t     f_cls;
  logic [CW-1:0]         f_index;
  logic [ADDR_WIDTH-1:0] f_dist;

  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [REC_W-1:0]      q_wdata;
  logic [REC_W-1:0]      q_rdata;

  nss_pkg::nss_cls_t     b_cls;
  logic [CW-1:0]         b_index;
  logic [ADDR_WIDTH-1:0] b_dist;

  // an entry beat is taken whenever the queue has room
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // front: holds the query of the current run, numbers entries and
  // classifies each one as below, above or equal with its distance
  nss_front #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sym_value  (in_sym_value),
    .query_addr (in_query_addr),
    .mode       (in_mode),
    .last_entry (in_last_entry),
    .rec_cls    (f_cls),
    .rec_index  (f_index),
    .rec_dist   (f_dist)
  );

  // classified record: flags, index, distance
  assign q_wdata = {f_cls, f_index, f_dist};

  // short queue so front and back stall independently
  nss_queue #(
    .WIDTH (REC_W),
    .DEPTH (nss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_cls   = nss_pkg::nss_cls_t'(q_rdata[REC_W-1 -: CLS_W]);
  assign b_index = q_rdata[ADDR_WIDTH +: CW];
  assign b_dist  = q_rdata[ADDR_WIDTH-1:0];

  // back: keeps nearest below / above / exact and registers the result beat
  nss_back #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_valid       (!q_empty),
    .rec_cls         (b_cls),
    .rec_index       (b_index),
    .rec_dist        (b_dist),
    .rec_pop         (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_offset      (out_offset)
  );

endmodule
